>>> rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int DEBOUNCE_W = 10;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(60);
    localparam logic [HOLD_W-1:0]     HOLD_RESET     = HOLD_W'(1000);
    localparam logic [DEBOUNCE_W-1:0] QUIET_MAX      = {DEBOUNCE_W{1'b1}};
    localparam logic [HOLD_W-1:0]     AGE_MAX        = {HOLD_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS = CFG_IDX_W'(0),
        REG_HOLD_TICKS     = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_ev_t;

endpackage

`default_nettype wire

>>> rtl/button_press_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                        Transfer when
// s_        in         s_valid, s_ready, s_pin_level                s_valid && s_ready
// m_        out        m_valid, m_ready, m_press_event              m_valid && m_ready
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// Each sample is captured in an input register and classified into the result register,
// so one sample is taken per cycle unless a stalled result holds the flow; a result
// passes through both registers in that order. The only limit is the single result
// register, which frees while m_ready is high. A stalled result holds both stages and
// the debounce state. Reset is synchronous on aresetn and loads the default settings;
// the config port is always ready.

module button_press_classifier_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_pin_level,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_press_event,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [bpc_pkg::DEBOUNCE_W-1:0] debounce_ticks_reg;
    logic [bpc_pkg::HOLD_W-1:0]     hold_ticks_reg;

    logic                           in_valid_reg;
    logic                           in_level_reg;

    logic                           last_level_reg, last_level_next;
    logic [bpc_pkg::DEBOUNCE_W-1:0] quiet_count_reg, quiet_count_next;
    logic                           press_open_reg, press_open_next;
    logic [bpc_pkg::HOLD_W-1:0]     press_age_reg, press_age_next;
    logic                           long_reported_reg, long_reported_next;

    logic                           out_valid_reg;
    bpc_pkg::press_ev_t             out_event_reg, out_event_next;

    logic                           advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_press_event = out_event_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        last_level_next    = last_level_reg;
        quiet_count_next   = quiet_count_reg;
        press_open_next    = press_open_reg;
        press_age_next     = press_age_reg;
        long_reported_next = long_reported_reg;
        out_event_next     = bpc_pkg::EV_NONE;

        if (press_open_reg && press_age_reg != bpc_pkg::AGE_MAX) begin
            press_age_next = press_age_reg + 1'b1;
        end

        if (in_level_reg != last_level_reg) begin
            last_level_next  = in_level_reg;
            quiet_count_next = '0;
        end else if (quiet_count_reg != bpc_pkg::QUIET_MAX) begin
            quiet_count_next = quiet_count_reg + 1'b1;
        end

        if (quiet_count_next >= debounce_ticks_reg) begin
            if (!in_level_reg) begin
                if (!press_open_reg) begin
                    press_open_next = 1'b1;
                    press_age_next  = '0;
                end
                if (!long_reported_reg && press_age_next > hold_ticks_reg) begin
                    long_reported_next = 1'b1;
                    out_event_next     = bpc_pkg::EV_LONG;
                end
            end else begin
                if (press_open_reg && !long_reported_reg) begin
                    out_event_next = bpc_pkg::EV_SHORT;
                end
                press_open_next    = 1'b0;
                press_age_next     = '0;
                long_reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= bpc_pkg::DEBOUNCE_RESET;
            hold_ticks_reg     <= bpc_pkg::HOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bpc_pkg::REG_DEBOUNCE_TICKS: begin
                    debounce_ticks_reg <= cfg_data[bpc_pkg::DEBOUNCE_W-1:0];
                end
                bpc_pkg::REG_HOLD_TICKS: begin
                    hold_ticks_reg <= cfg_data[bpc_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_pin_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg    <= 1'b1;
            quiet_count_reg   <= '0;
            press_open_reg    <= 1'b0;
            press_age_reg     <= '0;
            long_reported_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (advance) begin
                last_level_reg    <= last_level_next;
                quiet_count_reg   <= quiet_count_next;
                press_open_reg    <= press_open_next;
                press_age_reg     <= press_age_next;
                long_reported_reg <= long_reported_next;
                out_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= out_event_next;
        end
    end

endmodule

`default_nettype wire
